// ===== hdl/ejbp_pkg.sv =====
`timescale 1ns / 1ps

package ejbp_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 3;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_PROBE  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_MATCH    = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

endpackage

// ===== hdl/ejbp_in_if.sv =====
`timescale 1ns / 1ps

interface ejbp_in_if;
  import ejbp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] join_key;
  logic [TAG_W-1:0]        row_tag;

  modport source (output valid, output opcode, output join_key, output row_tag,
                  input ready);
  modport sink (input valid, input opcode, input join_key, input row_tag,
                output ready);
endinterface

// ===== hdl/ejbp_out_if.sv =====
`timescale 1ns / 1ps

interface ejbp_out_if;
  import ejbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    left_tag;
  logic [TAG_W-1:0]    right_tag;
  logic                last;

  modport source (output valid, output status, output left_tag, output right_tag,
                  output last, input ready);
  modport sink (input valid, input status, input left_tag, input right_tag,
                input last, output ready);
endinterface

// ===== hdl/equi_join_build_probe_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                  Transfer
// in_ch    in   opcode, join_key, row_tag                valid & ready
// out_ch   out  status, left_tag, right_tag, last        valid & ready
// cfg_*    in   cfg_wr_data (build_is_left)              cfg_wr_en
//
// Clear and insert: S_RESP loads the result register once the output register is free,
// then the core returns to S_IDLE. Probe: S_SCAN reads the table through one read port,
// one entry per cycle unless stalled, oldest first, and S_RESP loads the last result.
// A match result waits in a one-deep pending register so that last can be set;
// a further match stalls the scan while the output register is held by the sink.
// Synchronous reset clears control state; the table has no clearing pass.

module equi_join_build_probe_core #(
  parameter int TABLE_DEPTH = ejbp_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ejbp_in_if.sink        in_ch,
  ejbp_out_if.source     out_ch,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data
);
  import ejbp_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic signed [KEY_W-1:0] mem_key [TABLE_DEPTH];
  logic [TAG_W-1:0]        mem_tag [TABLE_DEPTH];

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic                    build_is_left_r;

  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [TAG_W-1:0]        tag_r;
  status_t                 stat_r;
  logic signed [KEY_W-1:0] rd_key_r;
  logic [TAG_W-1:0]        rd_tag_r;
  logic [TAG_W-1:0]        pend_tag_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [TAG_W-1:0]        out_left_r;
  logic [TAG_W-1:0]        out_right_r;
  logic                    out_last_r;

  logic                    in_xfer;
  logic                    out_busy;
  logic                    full;
  logic                    hit;
  logic                    stall;
  logic                    issue;
  logic                    wr_en;
  logic                    pend_ld;
  logic                    out_ld;
  status_t                 ld_status;
  logic [TAG_W-1:0]        ld_left;
  logic [TAG_W-1:0]        ld_right;
  logic                    ld_last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer = in_ch.valid & in_ch.ready;
  assign out_busy = out_vld_r & ~out_ch.ready;
  assign full = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign hit = rd_vld_r && (rd_key_r == key_r);
  assign stall = hit & pend_vld_r & out_busy;
  assign issue = (state_r == S_SCAN) && !stall && (idx_r < cnt_r);
  assign wr_en = in_xfer && (in_ch.opcode == OP_INSERT) && !full;
  assign pend_ld = (state_r == S_SCAN) && hit && !stall;

  assign out_ch.valid = out_vld_r;
  assign out_ch.status = out_status_r;
  assign out_ch.left_tag = out_left_r;
  assign out_ch.right_tag = out_right_r;
  assign out_ch.last = out_last_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    rd_vld_nxt = rd_vld_r;
    pend_vld_nxt = pend_vld_r;
    out_ld = 1'b0;
    ld_status = ST_MATCH;
    ld_left = '0;
    ld_right = '0;
    ld_last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.opcode)
            OP_CLEAR: begin
              cnt_nxt = '0;
              state_nxt = S_RESP;
            end
            OP_INSERT: begin
              if (!full) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              state_nxt = S_RESP;
            end
            OP_PROBE: begin
              idx_nxt = '0;
              rd_vld_nxt = 1'b0;
              pend_vld_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          rd_vld_nxt = issue;
          if (issue) begin
            idx_nxt = idx_r + CNT_W'(1);
          end
          if (hit) begin
            pend_vld_nxt = 1'b1;
            if (pend_vld_r) begin
              out_ld = 1'b1;
              ld_status = ST_MATCH;
              ld_left = build_is_left_r ? pend_tag_r : tag_r;
              ld_right = build_is_left_r ? tag_r : pend_tag_r;
              ld_last = 1'b0;
            end
          end
          if (!rd_vld_r && (idx_r == cnt_r)) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_busy) begin
          out_ld = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == OP_PROBE) begin
            if (pend_vld_r) begin
              ld_status = ST_MATCH;
              ld_left = build_is_left_r ? pend_tag_r : tag_r;
              ld_right = build_is_left_r ? tag_r : pend_tag_r;
            end else begin
              ld_status = ST_NOMATCH;
            end
          end else begin
            ld_status = stat_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_vld_nxt = out_ld | out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      rd_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      build_is_left_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        build_is_left_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_ch.opcode;
      key_r <= in_ch.join_key;
      tag_r <= in_ch.row_tag;
      if (in_ch.opcode == OP_CLEAR) begin
        stat_r <= ST_CLEARED;
      end else if (full) begin
        stat_r <= ST_FULL;
      end else begin
        stat_r <= ST_INSERTED;
      end
    end
    if (pend_ld) begin
      pend_tag_r <= rd_tag_r;
    end
    if (out_ld) begin
      out_status_r <= ld_status;
      out_left_r <= ld_left;
      out_right_r <= ld_right;
      out_last_r <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[cnt_r[ADDR_W-1:0]] <= in_ch.join_key;
      mem_tag[cnt_r[ADDR_W-1:0]] <= in_ch.row_tag;
    end
    if (issue) begin
      rd_key_r <= mem_key[idx_r[ADDR_W-1:0]];
      rd_tag_r <= mem_tag[idx_r[ADDR_W-1:0]];
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ejbp_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int SETTLE_CYCLES = TBL_DEPTH + 20;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } join_item_t;

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] left_tag;
    logic [TAG_W-1:0] right_tag;
    logic             last;
  } join_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  ejbp_in_if  in_ch ();
  ejbp_out_if out_ch ();

  equi_join_build_probe_core #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // mirror of the table
  logic [KEY_W-1:0] key_mem [TBL_DEPTH];
  logic [TAG_W-1:0] tag_mem [TBL_DEPTH];
  int               row_count;
  logic             build_left;

  join_item_t   item_q[$];
  join_result_t expected_rows[$];
  join_item_t   drv_item;
  join_result_t want;
  logic [KEY_W-1:0] key_pool [8];
  bit           calm;
  bit           hold_req;
  int           hold_left;
  int           fail_cnt;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void append_row(join_result_t r);
    expected_rows = {expected_rows, r};
  endfunction

  function automatic void push_row(status_t st, logic [TAG_W-1:0] lt, logic [TAG_W-1:0] rt,
                                   logic lst);
    join_result_t r;
    r.status = st;
    r.left_tag = lt;
    r.right_tag = rt;
    r.last = lst;
    append_row(r);
  endfunction

  function automatic void join_predict(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                       logic [TAG_W-1:0] tag);
    join_result_t prev;
    bit have_prev;
    have_prev = 1'b0;
    case (op)
      OP_CLEAR: begin
        row_count = 0;
        push_row(ST_CLEARED, '0, '0, 1'b1);
      end
      OP_INSERT: begin
        if (row_count >= TBL_DEPTH) begin
          push_row(ST_FULL, '0, '0, 1'b1);
        end else begin
          key_mem[row_count] = key;
          tag_mem[row_count] = tag;
          row_count++;
          push_row(ST_INSERTED, '0, '0, 1'b1);
        end
      end
      OP_PROBE: begin
        for (int i = 0; i < row_count; i++) begin
          if (key_mem[i] == key) begin
            if (have_prev) append_row(prev);
            prev.status = ST_MATCH;
            prev.left_tag = build_left ? tag_mem[i] : tag;
            prev.right_tag = build_left ? tag : tag_mem[i];
            prev.last = 1'b0;
            have_prev = 1'b1;
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          append_row(prev);
        end else begin
          push_row(ST_NOMATCH, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) join_predict(in_ch.opcode, in_ch.join_key, in_ch.row_tag);
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          drv_item = item_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= drv_item.op;
          in_ch.join_key <= drv_item.key;
          in_ch.row_tag <= drv_item.tag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result: status %0d left_tag %h right_tag %h last %0d",
                 out_ch.status, out_ch.left_tag, out_ch.right_tag, out_ch.last);
          fail_cnt++;
        end else begin
          want = expected_rows.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_cnt++;
          end
          if (out_ch.left_tag !== want.left_tag) begin
            $error("left_tag: expected %h, got %h", want.left_tag, out_ch.left_tag);
            fail_cnt++;
          end
          if (out_ch.right_tag !== want.right_tag) begin
            $error("right_tag: expected %h, got %h", want.right_tag, out_ch.right_tag);
            fail_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(0, 99) >= 20;
      end
    end
  end

  function automatic void add_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [TAG_W-1:0] tag);
    join_item_t it;
    it.op = op;
    it.key = key;
    it.tag = tag;
    item_q = {item_q, it};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic void refresh_pool();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
  endfunction

  // mix with occasional unused opcodes; clear_pct sets how often the table is emptied
  function automatic void queue_mix(int n, int clear_pct);
    int k;
    int r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) begin
        add_item(OP_CLEAR, $urandom, $urandom);
        k++;
      end else if (r < clear_pct + 3) begin
        add_item(OP_UNUSED, $urandom, $urandom);
      end else if (r < 55) begin
        add_item(OP_INSERT, pick_key(), pick_tag());
        k++;
      end else begin
        add_item(OP_PROBE, pick_key(), pick_tag());
        k++;
      end
    end
  endfunction

  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    while ((item_q.size() != 0 || in_ch.valid || expected_rows.size() != 0) &&
           guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    build_left = val;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.join_key = '0;
    in_ch.row_tag = '0;
    out_ch.ready = 1'b0;
    row_count = 0;
    build_left = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    fail_cnt = 0;
    refresh_pool();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every opcode, empty table, duplicate keys
    write_cfg(1'b1);
    add_item(OP_PROBE, '0, 32'h1234_5678);
    add_item(OP_UNUSED, '1, '1);
    add_item(OP_INSERT, KEY_MIN, '0);
    add_item(OP_INSERT, KEY_MAX, '1);
    add_item(OP_INSERT, '0, 32'h0000_0001);
    add_item(OP_INSERT, '1, 32'haaaa_5555);
    add_item(OP_INSERT, KEY_MIN, 32'h5555_aaaa);
    add_item(OP_PROBE, KEY_MIN, '1);
    add_item(OP_PROBE, KEY_MAX, '0);
    add_item(OP_PROBE, 32'h7fff_fffe, 32'h0bad_cafe);
    add_item(OP_PROBE, '1, 32'hdead_beef);
    add_item(OP_PROBE, '0, 32'h8000_0000);
    add_item(OP_CLEAR, '1, '1);
    add_item(OP_PROBE, KEY_MIN, 32'h0000_0002);
    add_item(OP_INSERT, 32'h0000_0001, 32'hffff_fffe);
    add_item(OP_PROBE, 32'h0000_0001, 32'h7fff_ffff);
    add_item(OP_CLEAR, '0, '0);
    settle();

    // fill the table, overflow it, probe with many matches
    write_cfg(1'b0);
    refresh_pool();
    add_item(OP_CLEAR, $urandom, $urandom);
    for (int i = 0; i < TBL_DEPTH; i++)
      add_item(OP_INSERT, (i < 40) ? KEY_MIN : pick_key(), pick_tag());
    add_item(OP_INSERT, KEY_MAX, $urandom);
    add_item(OP_INSERT, pick_key(), $urandom);
    for (int i = 0; i < 8; i++) add_item(OP_PROBE, key_pool[i], pick_tag());
    add_item(OP_PROBE, $urandom, $urandom);
    settle();

    // random, receiver stalls for a long stretch
    write_cfg(1'b1);
    refresh_pool();
    queue_mix(120, 4);
    hold_req = 1'b1;
    settle();

    // random, no idling, rare clears so the table fills
    write_cfg(1'b0);
    refresh_pool();
    calm = 1'b1;
    queue_mix(120, 1);
    settle();
    calm = 1'b0;

    write_cfg(1'b1);
    refresh_pool();
    queue_mix(120, 6);
    settle();

    if (expected_rows.size() != 0) begin
      $error("%0d expected results never arrived", expected_rows.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
